[sv/block_rms_level_meter_top_macros.svh]
// Assertion macros for the block RMS level meter.
// Used by block_rms_level_meter_top; expects clk and rst_n in scope.
`ifndef BLOCK_RMS_LEVEL_METER_TOP_MACROS_SVH
`define BLOCK_RMS_LEVEL_METER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BRLM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brlm: same-cycle check failed");
`define BRLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brlm: next-cycle check failed");
`else
`define BRLM_ASSERT_IMPLIES(label, ante, cons)
`define BRLM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/brlm_pkg.sv]
// Package of the block RMS level meter: widths, register codes, control structs.
// No dependencies.
package brlm_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 16;
    localparam int FIELD_BITS    = 16;
    localparam int COEF_BITS     = 16;
    localparam int MAG_BITS      = SAMPLE_BITS;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS - 1;
    localparam int SUM_BITS      = SQ_BITS + COUNT_BITS;
    localparam int QUO_BITS      = SQ_BITS;
    localparam int ROOT_BITS     = SAMPLE_BITS;
    localparam int WEIGHT_BITS   = COEF_BITS + 1;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 4;
    localparam int REG_IDX_BITS  = CFG_ADDR_BITS - 2;

    localparam logic [ROOT_BITS-1:0]   LEVEL_MAX        = ROOT_BITS'(1) << (ROOT_BITS - 1);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE       = WEIGHT_BITS'(1) << COEF_BITS;
    localparam logic [COUNT_BITS-1:0]  BLOCK_SIZE_RESET = COUNT_BITS'(480);

    localparam logic [REG_IDX_BITS-1:0] REG_BLOCK_SIZE = REG_IDX_BITS'(0);
    localparam logic [REG_IDX_BITS-1:0] REG_ATTACK     = REG_IDX_BITS'(1);
    localparam logic [REG_IDX_BITS-1:0] REG_RELEASE    = REG_IDX_BITS'(2);

    typedef struct packed {
        logic start;
        logic clear;
    } brlm_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } brlm_sts_t;

endpackage

[sv/brlm_if.sv]
// Word channels of the block RMS level meter: sample input and level output.
// Depends on brlm_pkg.
interface brlm_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [brlm_pkg::SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface brlm_out_if;
    logic                            valid;
    logic                            ready;
    logic [brlm_pkg::FIELD_BITS-1:0] level;
    logic [brlm_pkg::FIELD_BITS-1:0] block_rms;

    modport source (output valid, output level, output block_rms, input ready);
    modport sink (input valid, input level, input block_rms, output ready);
endinterface

[sv/brlm_sqacc.sv]
// Serial squarer and block accumulator: one multiplier bit per cycle, then one add.
// Depends on brlm_pkg.
module brlm_sqacc (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  brlm_pkg::brlm_ctl_t                     ctl,
    input  logic signed [brlm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [brlm_pkg::COUNT_BITS-1:0]         block_len,
    output brlm_pkg::brlm_sts_t                     sts,
    output logic [brlm_pkg::SUM_BITS-1:0]           sum,
    output logic                                    block_end
);
    import brlm_pkg::*;

    localparam int STEP_W = $clog2(MAG_BITS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAG_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  end_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [MAG_BITS-1:0]   mcand_reg;
    logic [MAG_BITS-1:0]   hi_reg;
    logic [MAG_BITS-1:0]   lo_reg;
    logic [SUM_BITS-1:0]   sum_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic [MAG_BITS-1:0]   raw;
    logic [MAG_BITS-1:0]   mag;
    logic [MAG_BITS:0]     psum;
    logic [MAG_BITS-1:0]   hi_next;
    logic [MAG_BITS-1:0]   lo_next;
    logic [2*MAG_BITS-1:0] product;
    logic [SUM_BITS-1:0]   sum_next;
    logic [COUNT_BITS-1:0] count_next;
    logic                  end_next;
    logic                  last_step;

    always_comb
    begin
        raw        = sample;
        mag        = raw[MAG_BITS-1] ? (~raw + MAG_BITS'(1)) : raw;
        psum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : (MAG_BITS + 1)'(0));
        hi_next    = psum[MAG_BITS:1];
        lo_next    = {psum[0], lo_reg[MAG_BITS-1:1]};
        product    = {hi_reg, lo_reg};
        sum_next   = sum_reg + SUM_BITS'(product[SQ_BITS-1:0]);
        count_next = count_reg + COUNT_BITS'(1);
        end_next   = (count_next >= block_len);
        last_step  = (step_reg == LAST_STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            end_reg   <= 1'b0;
            step_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.clear)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (last_step)
                begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    end_reg   <= end_next;
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            mcand_reg <= mag;
            hi_reg    <= '0;
            lo_reg    <= mag;
        end
        else if (busy_reg && !last_step)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign sts.busy  = busy_reg;
    assign sts.done  = done_reg;
    assign sum       = sum_reg;
    assign block_end = end_reg;

endmodule

[sv/brlm_div.sv]
// Restoring divider for the mean square: one quotient bit per cycle.
// Depends on brlm_pkg.
module brlm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [brlm_pkg::SUM_BITS-1:0]   dividend,
    input  logic [brlm_pkg::COUNT_BITS-1:0] divisor,
    output brlm_pkg::brlm_sts_t             sts,
    output logic [brlm_pkg::QUO_BITS-1:0]   quotient
);
    import brlm_pkg::*;

    localparam int STEP_W = $clog2(QUO_BITS);
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(QUO_BITS - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] dvs_reg;
    logic [QUO_BITS-1:0]   dq_reg;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;
    logic [COUNT_BITS-1:0] rem_next;
    logic [QUO_BITS-1:0]   dq_next;

    always_comb
    begin
        trial    = {rem_reg, dq_reg[QUO_BITS-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        dq_next  = {dq_reg[QUO_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= FIRST_STEP;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[SUM_BITS-1:QUO_BITS];
            dq_reg  <= dividend[QUO_BITS-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = dq_reg;

endmodule

[sv/brlm_sqrt.sv]
// Digit-by-digit integer square root: two radicand bits, one root bit per cycle.
// Depends on brlm_pkg.
module brlm_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [brlm_pkg::QUO_BITS-1:0]  radicand,
    output brlm_pkg::brlm_sts_t            sts,
    output logic [brlm_pkg::ROOT_BITS-1:0] root
);
    import brlm_pkg::*;

    localparam int RAD_BITS = 2 * ROOT_BITS;
    localparam int STEP_W   = $clog2(ROOT_BITS);
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(ROOT_BITS - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [ROOT_BITS-1:0] rem_reg;
    logic [ROOT_BITS-1:0] root_reg;

    logic [ROOT_BITS+1:0] tmp;
    logic [ROOT_BITS+1:0] trial;
    logic [ROOT_BITS+1:0] diff;
    logic                 fits;

    always_comb
    begin
        tmp   = {rem_reg, rad_reg[RAD_BITS-1 -: 2]};
        trial = {root_reg, 2'b01};
        diff  = tmp - trial;
        fits  = (tmp >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= FIRST_STEP;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= RAD_BITS'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? diff[ROOT_BITS-1:0] : tmp[ROOT_BITS-1:0];
            root_reg <= {root_reg[ROOT_BITS-2:0], fits};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = root_reg;

endmodule

[sv/brlm_smooth.sv]
// Attack/release smoother: serial weighted sum of block RMS and held level.
// Holds the level register. Depends on brlm_pkg.
module brlm_smooth (
    input  logic                           clk,
    input  logic                           rst_n,
    input  brlm_pkg::brlm_ctl_t            ctl,
    input  logic [brlm_pkg::ROOT_BITS-1:0] rms,
    input  logic [brlm_pkg::COEF_BITS-1:0] attack_coeff,
    input  logic [brlm_pkg::COEF_BITS-1:0] release_coeff,
    output brlm_pkg::brlm_sts_t            sts,
    output logic [brlm_pkg::ROOT_BITS-1:0] level
);
    import brlm_pkg::*;

    localparam int STEP_W = $clog2(WEIGHT_BITS);
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'(WEIGHT_BITS - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [ROOT_BITS-1:0]   held_reg;
    logic [ROOT_BITS-1:0]   rms_reg;
    logic [WEIGHT_BITS-1:0] w_reg;
    logic [COEF_BITS-1:0]   c_reg;
    logic [ROOT_BITS:0]     acc_reg;

    logic [COEF_BITS-1:0]   c_sel;
    logic [WEIGHT_BITS-1:0] w_init;
    logic [ROOT_BITS:0]     addend;
    logic [ROOT_BITS+1:0]   psum;
    logic [ROOT_BITS:0]     acc_next;
    logic [ROOT_BITS-1:0]   level_next;

    always_comb
    begin
        c_sel      = (rms < held_reg) ? release_coeff : attack_coeff;
        w_init     = WEIGHT_ONE - {1'b0, c_sel};
        addend     = {1'b0, (w_reg[0] ? rms_reg : ROOT_BITS'(0))}
                   + {1'b0, (c_reg[0] ? held_reg : ROOT_BITS'(0))};
        psum       = {1'b0, acc_reg} + {1'b0, addend};
        acc_next   = psum[ROOT_BITS+1:1];
        level_next = psum[ROOT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            held_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.clear)
            begin
                held_reg <= '0;
            end
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= FIRST_STEP;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    held_reg <= level_next;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rms_reg <= rms;
            w_reg   <= w_init;
            c_reg   <= c_sel;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            w_reg   <= w_reg >> 1;
            c_reg   <= c_reg >> 1;
            acc_reg <= acc_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign level    = held_reg;

endmodule

[sv/block_rms_level_meter_top.sv]
// Block RMS level meter, top level: APB registers, sequencer, output word register.
// Depends on brlm_pkg, brlm_if, brlm_sqacc, brlm_div, brlm_sqrt, brlm_smooth
// and block_rms_level_meter_top_macros.svh.
//
// Usage:
//   samples carries one signed Q1.15 sample per word; levels carries one
//   word per finished block: the smoothed level and the raw block RMS.
//   Each sample is squared one multiplier bit per cycle in the squarer, and
//   samples.ready stays low until the squarer is done, so a new sample is
//   taken only after the last one is squared. The last sample of a block
//   then runs the divider, the root unit and the smoother in that order, and
//   its level word is loaded into the output register, and samples.ready
//   stays low until that load. These serial units set the throughput.
//   The result waits in an output register, so a new sample is taken while
//   levels stalls; a further result waits until that register frees.
//   Reset clears sum, count and level; block_size becomes 480, coefficients 0.
//   Writing block_size, attack_coeff or release_coeff clears the same state.
`include "block_rms_level_meter_top_macros.svh"

module block_rms_level_meter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    brlm_in_if.sink                            samples,
    brlm_out_if.source                         levels,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [brlm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [brlm_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [brlm_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import brlm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_DIV,
        S_ROOT,
        S_SMOOTH,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic                    out_valid_reg;
    logic [FIELD_BITS-1:0]   level_out_reg;
    logic [FIELD_BITS-1:0]   rms_out_reg;
    logic [COUNT_BITS-1:0]   block_size_reg;
    logic [COEF_BITS-1:0]    attack_reg;
    logic [COEF_BITS-1:0]    release_reg;

    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_write;
    logic                    cfg_clear;
    logic [COUNT_BITS-1:0]   block_len;
    logic                    accept_in;
    logic                    emit_ok;
    logic                    div_start;

    brlm_ctl_t               sq_ctl;
    brlm_ctl_t               sm_ctl;
    brlm_sts_t               sq_sts;
    brlm_sts_t               div_sts;
    brlm_sts_t               root_sts;
    brlm_sts_t               sm_sts;
    logic [SUM_BITS-1:0]     sq_sum;
    logic                    sq_end;
    logic [QUO_BITS-1:0]     mean_sq;
    logic [ROOT_BITS-1:0]    root_val;
    logic [ROOT_BITS-1:0]    held_level;
    logic [3:0]              unit_busy;
    logic                    out_in_range;

    assign reg_idx   = paddr[CFG_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (reg_idx)
            REG_BLOCK_SIZE:
            begin
                cfg_clear = cfg_write;
                prdata    = CFG_DATA_BITS'(block_size_reg);
            end
            REG_ATTACK:
            begin
                cfg_clear = cfg_write;
                prdata    = CFG_DATA_BITS'(attack_reg);
            end
            REG_RELEASE:
            begin
                cfg_clear = cfg_write;
                prdata    = CFG_DATA_BITS'(release_reg);
            end
            default:
            begin
                cfg_clear = 1'b0;
                prdata    = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= BLOCK_SIZE_RESET;
            attack_reg     <= '0;
            release_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_BLOCK_SIZE: block_size_reg <= pwdata[COUNT_BITS-1:0];
                REG_ATTACK:     attack_reg     <= pwdata[COEF_BITS-1:0];
                REG_RELEASE:    release_reg    <= pwdata[COEF_BITS-1:0];
                default:        ;
            endcase
        end
    end

    assign block_len = (block_size_reg == '0) ? COUNT_BITS'(1) : block_size_reg;

    assign samples.ready = (state_reg == S_IDLE);
    assign accept_in     = samples.valid && samples.ready;
    assign div_start     = sq_sts.done && sq_end;
    assign emit_ok       = (state_reg == S_EMIT) && (!out_valid_reg || levels.ready);

    assign sq_ctl.start = accept_in;
    assign sq_ctl.clear = cfg_clear || div_start;
    assign sm_ctl.start = root_sts.done;
    assign sm_ctl.clear = cfg_clear;

    brlm_sqacc u_sqacc (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq_ctl),
        .sample    (samples.sample),
        .block_len (block_len),
        .sts       (sq_sts),
        .sum       (sq_sum),
        .block_end (sq_end)
    );

    brlm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sq_sum),
        .divisor  (block_len),
        .sts      (div_sts),
        .quotient (mean_sq)
    );

    brlm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_sts.done),
        .radicand (mean_sq),
        .sts      (root_sts),
        .root     (root_val)
    );

    brlm_smooth u_smooth (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (sm_ctl),
        .rms           (root_val),
        .attack_coeff  (attack_reg),
        .release_coeff (release_reg),
        .sts           (sm_sts),
        .level         (held_level)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            level_out_reg <= '0;
            rms_out_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (sq_sts.done)
                    begin
                        state_reg <= sq_end ? S_DIV : S_IDLE;
                    end
                end
                S_DIV:
                begin
                    if (div_sts.done)
                    begin
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (root_sts.done)
                    begin
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SMOOTH:
                begin
                    if (sm_sts.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (emit_ok)
            begin
                out_valid_reg <= 1'b1;
                level_out_reg <= FIELD_BITS'(held_level);
                rms_out_reg   <= FIELD_BITS'(root_val);
            end
            else if (levels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign levels.valid     = out_valid_reg;
    assign levels.level     = level_out_reg;
    assign levels.block_rms = rms_out_reg;

    assign unit_busy    = {sq_sts.busy, div_sts.busy, root_sts.busy, sm_sts.busy};
    assign out_in_range = (level_out_reg <= FIELD_BITS'(LEVEL_MAX))
                       && (rms_out_reg <= FIELD_BITS'(LEVEL_MAX));

    `BRLM_ASSERT_NEXT(a_block_end_starts_div, sq_sts.done && sq_end, div_sts.busy)
    `BRLM_ASSERT_IMPLIES(a_one_unit_busy, 1'b1, $onehot0(unit_busy))
    `BRLM_ASSERT_IMPLIES(a_ready_units_idle, samples.ready, unit_busy == '0)
    `BRLM_ASSERT_IMPLIES(a_out_in_range, out_valid_reg, out_in_range)

endmodule

[tb/brlm_level_checker.sv]
`timescale 1ns / 100ps
// Checker for the block RMS level meter: follows register writes and accepted sample
// words, predicts each level word and compares it with the output channel.
// Depends on brlm_pkg and the brlm_in_if / brlm_out_if interfaces.

module brlm_level_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    brlm_in_if                                 samples,
    brlm_out_if                                levels,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [brlm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [brlm_pkg::CFG_DATA_BITS-1:0] pwdata,
    output int                                 mismatches,
    output int                                 pending
);
    import brlm_pkg::*;

    typedef struct packed {
        logic [FIELD_BITS-1:0] level;
        logic [FIELD_BITS-1:0] block_rms;
    } level_word_t;

    logic [COUNT_BITS-1:0] block_len;
    logic [COEF_BITS-1:0]  attack_w;
    logic [COEF_BITS-1:0]  release_w;
    logic [63:0]           energy;
    logic [COUNT_BITS-1:0] taken;
    logic [FIELD_BITS-1:0] held;
    level_word_t           expected_levels[$];

    always @(posedge clk or negedge rst_n)
    begin : track
        level_word_t           got;
        level_word_t           want;
        logic                  wipe;
        logic [SAMPLE_BITS-1:0] raw;
        logic [SAMPLE_BITS:0]  mag;
        logic [63:0]           sq;
        logic [63:0]           mean;
        logic [63:0]           root;
        logic [63:0]           trial;
        logic [63:0]           mix;
        logic [COUNT_BITS-1:0] divisor;
        logic [ROOT_BITS-1:0]  rms;
        logic [COEF_BITS-1:0]  w;

        if (!rst_n)
        begin
            block_len = BLOCK_SIZE_RESET;
            attack_w = '0;
            release_w = '0;
            energy = '0;
            taken = '0;
            held = '0;
            expected_levels.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (levels.valid && levels.ready)
            begin
                got.level = levels.level;
                got.block_rms = levels.block_rms;
                if (expected_levels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected level word: level %0d block_rms %0d",
                                 got.level, got.block_rms);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (want.level != got.level || want.block_rms != got.block_rms)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("level word mismatch: expected level %0d block_rms %0d,",
                                     want.level, want.block_rms,
                                     " got level %0d block_rms %0d",
                                     got.level, got.block_rms);
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                wipe = 1'b1;
                case (paddr[CFG_ADDR_BITS-1:2])
                    REG_BLOCK_SIZE: block_len = pwdata[COUNT_BITS-1:0];
                    REG_ATTACK:     attack_w = pwdata[COEF_BITS-1:0];
                    REG_RELEASE:    release_w = pwdata[COEF_BITS-1:0];
                    default:        wipe = 1'b0;
                endcase
                if (wipe)
                begin
                    energy = '0;
                    taken = '0;
                    held = '0;
                end
            end

            if (samples.valid && samples.ready)
            begin
                raw = samples.sample;
                mag = raw[SAMPLE_BITS-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
                sq = 64'(mag) * 64'(mag);
                energy = (energy > ~sq) ? '1 : energy + sq;
                taken = taken + COUNT_BITS'(1);
                divisor = (block_len == '0) ? COUNT_BITS'(1) : block_len;
                if (taken >= divisor)
                begin
                    mean = energy / 64'(divisor);
                    root = '0;
                    for (int b = 23; b >= 0; b--)
                    begin
                        trial = root | (64'd1 << b);
                        if (trial * trial <= mean)
                            root = trial;
                    end
                    rms = root[ROOT_BITS-1:0];
                    w = (rms < held) ? release_w : attack_w;
                    mix = (64'(rms) * (64'd65536 - 64'(w)) + 64'(held) * 64'(w)) >> 16;
                    held = mix[FIELD_BITS-1:0];
                    want.level = held;
                    want.block_rms = rms;
                    expected_levels.push_back(want);
                    energy = '0;
                    taken = '0;
                end
            end

            pending = expected_levels.size();
        end
    end

endmodule

[tb/block_rms_level_meter_top_tb.sv]
`timescale 1ns / 100ps
// Top of the block RMS level meter testbench: clock, reset, APB register writes and
// sample words with random idling; the verdict comes from brlm_level_checker and a watchdog.
// Depends on brlm_pkg, the brlm interfaces, block_rms_level_meter_top and the checker.

module block_rms_level_meter_top_tb;
    import brlm_pkg::*;

    localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = REG_IDX_BITS'(3);
    localparam int SETTLE_CYCLES  = 120;
    localparam int DRAIN_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1150;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       mismatches;
    int                       pending;
    int                       quiet_cycles = 0;
    int                       stall_left = 0;
    bit                       calm = 1'b0;

    brlm_in_if  samples ();
    brlm_out_if levels ();

    block_rms_level_meter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .levels  (levels),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    brlm_level_checker level_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .levels     (levels),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        levels.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm)
                levels.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                levels.ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                levels.ready <= 1'b0;
            end
            else
                levels.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (levels.valid && levels.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("block_rms_level_meter_top verification failed");
        $finish;
    end

    task automatic apb_write(input logic [REG_IDX_BITS-1:0] idx, input logic [15:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // drop valid, wait out every level word, then let the pipeline settle
    task automatic quiesce();
        @(negedge clk);
        samples.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] bs, input logic [15:0] att,
                              input logic [15:0] rel);
        quiesce();
        apb_write(REG_BLOCK_SIZE, bs);
        apb_write(REG_ATTACK, att);
        apb_write(REG_RELEASE, rel);
    endtask

    task automatic push_sample(input logic [15:0] value);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            samples.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.sample <= value;
        do @(posedge clk); while (!samples.ready);
    endtask

    function automatic logic [15:0] pick_sample(input bit loud);
        int r;
        r = $urandom_range(0, 9);
        if (loud)
        begin
            if (r == 0)
                return 16'h8000;
            if (r == 1)
                return 16'h7FFF;
            return 16'($urandom);
        end
        if (r < 3)
            return 16'h0000;
        return 16'($urandom_range(0, 512) - 256);
    endfunction

    function automatic logic [15:0] pick_coef();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    initial
    begin
        int          phase;
        int          n;
        int          sent;
        logic [15:0] bs;
        logic [15:0] att;
        logic [15:0] rel;
        bit          loud;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        samples.valid = 1'b0;
        samples.sample = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one-sample blocks, no smoothing: level follows the block RMS
        set_config(16'd1, 16'h0000, 16'h0000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        push_sample(16'h8000);

        // heaviest smoothing on both slopes
        set_config(16'd1, 16'hFFFF, 16'hFFFF);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'h4000);

        // zero block size ends a block on every sample
        set_config(16'd0, 16'h8000, 16'h4000);
        push_sample(16'd100);
        push_sample(16'hFF9C);

        set_config(16'd2, 16'h8000, 16'h4000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'h0000);
        push_sample(16'h03E8);
        push_sample(16'hFC18);

        // write to an unmapped register mid-block: the partial sum must survive
        push_sample(16'h1234);
        quiesce();
        apb_write(REG_UNUSED, 16'hFFFF);
        push_sample(16'hEDCC);

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case (phase)
                0:
                begin
                    bs = 16'd1;
                    att = 16'h0000;
                    rel = 16'hFFFF;
                    n = 60;
                end
                1:
                begin
                    bs = 16'd0;
                    att = 16'hFFFF;
                    rel = 16'h0000;
                    n = 60;
                end
                2:
                begin
                    bs = 16'hFFFF;
                    att = pick_coef();
                    rel = pick_coef();
                    n = 25;
                end
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                        bs = 16'($urandom_range(20, 64));
                    else
                        bs = 16'($urandom_range(1, 12));
                    att = pick_coef();
                    rel = pick_coef();
                    n = $urandom_range(50, 110);
                end
            endcase
            if (RANDOM_ITEMS - sent - n < 100)
            begin
                n = RANDOM_ITEMS - sent;
                calm = 1'b1;
            end
            else
                calm = ($urandom_range(0, 3) == 0);
            set_config(bs, att, rel);
            loud = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                if (phase == 3 && i == n / 2)
                    quiesce();
                if ($urandom_range(0, 11) == 0)
                    loud = !loud;
                push_sample(pick_sample(loud));
            end
            sent += n;
            phase++;
        end

        @(negedge clk);
        samples.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("block_rms_level_meter_top verification clean");
        else
            $display("block_rms_level_meter_top verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/brlm_pkg.sv
sv/brlm_if.sv
sv/brlm_sqacc.sv
sv/brlm_div.sv
sv/brlm_sqrt.sv
sv/brlm_smooth.sv
sv/block_rms_level_meter_top.sv
tb/brlm_level_checker.sv
tb/block_rms_level_meter_top_tb.sv
